// ===== design/ofv_pkg.sv =====
// Shared constants, codes and vector types for the orthonormal frame block.
// No dependencies.
package ofv_pkg;

  // Input coordinates are signed Q3.12, unit axes signed Q1.14
  localparam int COORD_W = 16;
  localparam int FRAC    = 14;
  localparam int UNIT_W  = FRAC + 2;
  localparam int PROD_W  = COORD_W + UNIT_W;

  // Primary axis codes
  localparam logic [1:0] FUNC_Y = 2'd0;
  localparam logic [1:0] FUNC_X = 2'd1;
  localparam logic [1:0] FUNC_Z = 2'd2;

  typedef logic [2:0][COORD_W-1:0] coord_vec_t;
  typedef logic [2:0][UNIT_W-1:0]  unit_vec_t;
  typedef logic [2:0][PROD_W-1:0]  prod_vec_t;

  // Words carried alongside the first and second normalizer
  typedef struct packed {
    logic [1:0] func;
    coord_vec_t other;
  } side1_t;

  typedef struct packed {
    logic [1:0] func;
    unit_vec_t  u1;
    logic       zero1;
  } side2_t;

endpackage

// ===== design/ofv_norm.sv =====
// Pipelined exact normalizer: squares, length, restoring divider and square root.
// Depends on ofv_pkg.
module ofv_norm import ofv_pkg::*; #(
  parameter int IN_W   = COORD_W,
  parameter int FRAC_W = FRAC,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [2:0][IN_W-1:0]       in_vec,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [2:0][FRAC_W+1:0]     out_unit,
  output logic                       out_zero,
  output logic [SIDE_W-1:0]          out_side
);

  // Component q = (isqrt(floor(m^2 * 2^SHIFT / L)) + 1) / 2
  localparam int SQ_W  = 2 * IN_W;
  localparam int LEN_W = SQ_W + 2;
  localparam int REM_W = LEN_W + 1;
  localparam int SHIFT = 2 * FRAC_W + 2;
  localparam int QB    = SHIFT + 1;
  localparam int SW    = QB + 1;
  localparam int SI    = SW / 2;
  localparam int UW    = FRAC_W + 2;

  // Stage A: magnitudes and squares
  logic                va_r;
  logic [2:0]          sign_a_r;
  logic [SQ_W-1:0]     sq_a_r [3];
  logic                zero_a_r;
  logic [SIDE_W-1:0]   side_a_r;
  logic [IN_W-1:0]     mag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = in_vec[i][IN_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sign_a_r[i] <= in_vec[i][IN_W-1];
        sq_a_r[i]   <= SQ_W'(mag[i]) * SQ_W'(mag[i]);
      end
      zero_a_r <= (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
      side_a_r <= in_side;
    end
  end

  // Stage B: squared length
  logic                vb_r;
  logic [2:0]          sign_b_r;
  logic [SQ_W-1:0]     sq_b_r [3];
  logic [LEN_W-1:0]    len_b_r;
  logic                zero_b_r;
  logic [SIDE_W-1:0]   side_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sign_b_r <= sign_a_r;
      sq_b_r   <= sq_a_r;
      len_b_r  <= LEN_W'(sq_a_r[0]) + LEN_W'(sq_a_r[1]) + LEN_W'(sq_a_r[2]);
      zero_b_r <= zero_a_r;
      side_b_r <= side_a_r;
    end
  end

  // Divider: one quotient bit per stage
  logic [QB-1:0]       vd_r;
  logic [LEN_W-1:0]    rem_r  [QB][3];
  logic [QB-1:0]       quo_r  [QB][3];
  logic [LEN_W-1:0]    len_d_r  [QB];
  logic [2:0]          sign_d_r [QB];
  logic                zero_d_r [QB];
  logic [SIDE_W-1:0]   side_d_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [LEN_W-1:0]  len_in;
    logic [2:0]        sign_in;
    logic              zero_in;
    logic              v_in;
    logic [SIDE_W-1:0] side_in;

    if (k == 0) begin : g_first
      assign len_in  = len_b_r;
      assign sign_in = sign_b_r;
      assign zero_in = zero_b_r;
      assign v_in    = vb_r;
      assign side_in = side_b_r;
    end else begin : g_next
      assign len_in  = len_d_r[k-1];
      assign sign_in = sign_d_r[k-1];
      assign zero_in = zero_d_r[k-1];
      assign v_in    = vd_r[k-1];
      assign side_in = side_d_r[k-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [LEN_W-1:0] rem_in;
      logic [QB-1:0]    quo_in;
      logic             bit_in;
      logic [REM_W-1:0] rem_sh;
      logic             take;

      // Dividend is m^2 shifted up; only its lowest bit enters after the seed
      if (k == 0) begin : g_seed
        assign rem_in = LEN_W'(sq_b_r[i] >> 1);
        assign quo_in = '0;
        assign bit_in = sq_b_r[i][0];
      end else begin : g_chain
        assign rem_in = rem_r[k-1][i];
        assign quo_in = quo_r[k-1][i];
        assign bit_in = 1'b0;
      end

      assign rem_sh = {rem_in, bit_in};
      assign take   = rem_sh >= REM_W'(len_in);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][i] <= take ? LEN_W'(rem_sh - REM_W'(len_in)) : LEN_W'(rem_sh);
          quo_r[k][i] <= {quo_in[QB-2:0], take};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k] <= 1'b0;
      end else if (en) begin
        vd_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_d_r[k]  <= len_in;
        sign_d_r[k] <= sign_in;
        zero_d_r[k] <= zero_in;
        side_d_r[k] <= side_in;
      end
    end
  end

  // Square root: one result bit per stage
  logic [SI-1:0]       vs_r;
  logic [SW-1:0]       op_s_r  [SI][3];
  logic [SW-1:0]       res_s_r [SI][3];
  logic [2:0]          sign_s_r [SI];
  logic                zero_s_r [SI];
  logic [SIDE_W-1:0]   side_s_r [SI];

  for (genvar j = 0; j < SI; j++) begin : g_sqrt
    localparam logic [SW-1:0] ONE = {{(SW-1){1'b0}}, 1'b1} << (SW - 2 - 2 * j);
    logic [2:0]        sign_in;
    logic              zero_in;
    logic              v_in;
    logic [SIDE_W-1:0] side_in;

    if (j == 0) begin : g_first
      assign sign_in = sign_d_r[QB-1];
      assign zero_in = zero_d_r[QB-1];
      assign v_in    = vd_r[QB-1];
      assign side_in = side_d_r[QB-1];
    end else begin : g_next
      assign sign_in = sign_s_r[j-1];
      assign zero_in = zero_s_r[j-1];
      assign v_in    = vs_r[j-1];
      assign side_in = side_s_r[j-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [SW-1:0] op_in;
      logic [SW-1:0] res_in;
      logic [SW:0]   trial;
      logic          take;

      if (j == 0) begin : g_seed
        assign op_in  = SW'(quo_r[QB-1][i]);
        assign res_in = '0;
      end else begin : g_chain
        assign op_in  = op_s_r[j-1][i];
        assign res_in = res_s_r[j-1][i];
      end

      assign trial = {1'b0, res_in} + {1'b0, ONE};
      assign take  = {1'b0, op_in} >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          op_s_r[j][i]  <= take ? SW'({1'b0, op_in} - trial) : op_in;
          res_s_r[j][i] <= take ? (res_in >> 1) + ONE : res_in >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[j] <= 1'b0;
      end else if (en) begin
        vs_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sign_s_r[j] <= sign_in;
        zero_s_r[j] <= zero_in;
        side_s_r[j] <= side_in;
      end
    end
  end

  // Final stage: halve the odd bound, apply sign, force zero vectors
  logic                vf_r;
  logic [2:0][UW-1:0]  unit_f_r;
  logic                zero_f_r;
  logic [SIDE_W-1:0]   side_f_r;
  logic [UW-1:0]       half [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      half[i] = UW'(({1'b0, res_s_r[SI-1][i][UW-1:0]} + 1'b1) >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= vs_r[SI-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (zero_s_r[SI-1]) begin
          unit_f_r[i] <= '0;
        end else if (sign_s_r[SI-1][i]) begin
          unit_f_r[i] <= -half[i];
        end else begin
          unit_f_r[i] <= half[i];
        end
      end
      zero_f_r <= zero_s_r[SI-1];
      side_f_r <= side_s_r[SI-1];
    end
  end

  assign out_valid = vf_r;
  assign out_unit  = unit_f_r;
  assign out_zero  = zero_f_r;
  assign out_side  = side_f_r;

  // A zero-length input leaves a zero unit vector
  a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero |-> out_unit == '0)
    else $error("zero-length word produced a nonzero unit vector");

  // Components never leave -2^F..2^F
  for (genvar i = 0; i < 3; i++) begin : g_chk
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> ($signed(out_unit[i]) <= $signed(UW'(1) << FRAC_W)) &&
                    ($signed(out_unit[i]) >= -$signed(UW'(1) << FRAC_W)))
      else $error("unit component out of range");
  end

  // A stalled pipeline holds its output
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(out_valid) && $stable(out_unit))
    else $error("normalizer output moved during a stall");

endmodule

// ===== design/orthonormal_frame_from_two_vectors.sv =====
// Top level of the orthonormal frame block: input stage, two normalizers,
// cross products and output register. Depends on ofv_pkg and ofv_norm.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one word per cycle: a mode
//   (in_func: Y, X or Z primary axis) and two Q3.12 vectors. The result
//   channel (out_valid/out_ready) gives one word per input: the three unit
//   rows of the rotation matrix in Q1.14 and a degenerate flag.
//   Throughput is one word per cycle while the receiver keeps up. From
//   accept to out_valid a word passes the input stage, two normalizers of
//   50 stages each (31 divider bit stages and 16 square-root bit stages set
//   that depth), two cross-product stages after each normalizer and the output
//   register. When the receiver stalls, every stage holds; the input register
//   still takes one word while it is empty, so in_ready drops once that
//   register is full. Nothing is lost or repeated across a stall.
//   Reset (synchronous, active low) clears all valid bits; the block then
//   accepts at once. A zero-length vector or parallel vectors zero the rows
//   that depend on them and raise out_degenerate; the unused mode code gives
//   three zero rows with out_degenerate set.
module orthonormal_frame_from_two_vectors import ofv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_first_x,
  input  logic signed [15:0] in_first_y,
  input  logic signed [15:0] in_first_z,
  input  logic signed [15:0] in_second_x,
  input  logic signed [15:0] in_second_y,
  input  logic signed [15:0] in_second_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_xaxis_x,
  output logic signed [15:0] out_xaxis_y,
  output logic signed [15:0] out_xaxis_z,
  output logic signed [15:0] out_yaxis_x,
  output logic signed [15:0] out_yaxis_y,
  output logic signed [15:0] out_yaxis_z,
  output logic signed [15:0] out_zaxis_x,
  output logic signed [15:0] out_zaxis_y,
  output logic signed [15:0] out_zaxis_z,
  output logic               out_degenerate
);

  localparam int S1_W = $bits(side1_t);
  localparam int S2_W = $bits(side2_t);

  logic out_valid_r;
  logic adv;

  // Whole pipeline advances unless a result waits
  assign adv      = out_ready || !out_valid_r;

  // Input stage
  logic       v0_r;
  logic [1:0] func0_r;
  coord_vec_t a0_r;
  coord_vec_t b0_r;

  assign in_ready = adv || !v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      v0_r <= 1'b1;
    end else if (adv) begin
      v0_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      func0_r <= in_func;
      a0_r    <= {in_first_z, in_first_y, in_first_x};
      b0_r    <= {in_second_z, in_second_y, in_second_x};
    end
  end

  // First normalizer: X mode takes the first vector, the others the second
  side1_t     s1_in;
  coord_vec_t n1_vec;
  logic       n1_valid;
  unit_vec_t  n1_unit;
  logic       n1_zero;
  logic [S1_W-1:0] n1_side_raw;
  side1_t     n1_side;

  assign n1_vec       = (func0_r == FUNC_X) ? a0_r : b0_r;
  assign s1_in.func   = func0_r;
  assign s1_in.other  = (func0_r == FUNC_X) ? b0_r : a0_r;

  ofv_norm #(
    .IN_W   (COORD_W),
    .FRAC_W (FRAC),
    .SIDE_W (S1_W)
  ) u_norm1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v0_r),
    .in_vec    (n1_vec),
    .in_side   (S1_W'(s1_in)),
    .out_valid (n1_valid),
    .out_unit  (n1_unit),
    .out_zero  (n1_zero),
    .out_side  (n1_side_raw)
  );

  assign n1_side = side1_t'(n1_side_raw);

  // Products of other x u1
  logic       vc1_r;
  prod_vec_t  pa_r;
  prod_vec_t  pb_r;
  logic [1:0] func_c1_r;
  unit_vec_t  u1_c1_r;
  logic       z1_c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc1_r <= 1'b0;
    end else if (adv) begin
      vc1_r <= n1_valid;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_c1
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (adv) begin
        pa_r[i] <= PROD_W'($signed(n1_side.other[J]) * $signed(n1_unit[K]));
        pb_r[i] <= PROD_W'($signed(n1_side.other[K]) * $signed(n1_unit[J]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func_c1_r <= n1_side.func;
      u1_c1_r   <= n1_unit;
      z1_c1_r   <= n1_zero;
    end
  end

  // Exact cross product, flipped for X mode where the unit axis leads
  logic       vc2_r;
  prod_vec_t  t_c2_r;
  logic [1:0] func_c2_r;
  unit_vec_t  u1_c2_r;
  logic       z1_c2_r;
  prod_vec_t  t_diff;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_diff[i] = pa_r[i] - pb_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc2_r <= 1'b0;
    end else if (adv) begin
      vc2_r <= vc1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t_c2_r[i] <= (func_c1_r == FUNC_X) ? -t_diff[i] : t_diff[i];
      end
      func_c2_r <= func_c1_r;
      u1_c2_r   <= u1_c1_r;
      z1_c2_r   <= z1_c1_r;
    end
  end

  // Second normalizer
  side2_t    s2_in;
  logic      n2_valid;
  unit_vec_t n2_unit;
  logic      n2_zero;
  logic [S2_W-1:0] n2_side_raw;
  side2_t    n2_side;

  assign s2_in.func  = func_c2_r;
  assign s2_in.u1    = u1_c2_r;
  assign s2_in.zero1 = z1_c2_r;

  ofv_norm #(
    .IN_W   (PROD_W),
    .FRAC_W (FRAC),
    .SIDE_W (S2_W)
  ) u_norm2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (vc2_r),
    .in_vec    (t_c2_r),
    .in_side   (S2_W'(s2_in)),
    .out_valid (n2_valid),
    .out_unit  (n2_unit),
    .out_zero  (n2_zero),
    .out_side  (n2_side_raw)
  );

  assign n2_side = side2_t'(n2_side_raw);

  // Products of u1 x u2
  logic       vx1_r;
  prod_vec_t  qa_r;
  prod_vec_t  qb_r;
  logic [1:0] func_x1_r;
  unit_vec_t  u1_x1_r;
  unit_vec_t  u2_x1_r;
  logic       z1_x1_r;
  logic       z2_x1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx1_r <= 1'b0;
    end else if (adv) begin
      vx1_r <= n2_valid;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_x1
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (adv) begin
        qa_r[i] <= PROD_W'($signed(n2_side.u1[J]) * $signed(n2_unit[K]));
        qb_r[i] <= PROD_W'($signed(n2_side.u1[K]) * $signed(n2_unit[J]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func_x1_r <= n2_side.func;
      u1_x1_r   <= n2_side.u1;
      u2_x1_r   <= n2_unit;
      z1_x1_r   <= n2_side.zero1;
      z2_x1_r   <= n2_zero;
    end
  end

  // Round the unit cross product to Q1.14, ties away from zero, and clamp
  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (FRAC - 1);
  localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << FRAC;

  logic       vx2_r;
  unit_vec_t  w_x2_r;
  logic [1:0] func_x2_r;
  unit_vec_t  u1_x2_r;
  unit_vec_t  u2_x2_r;
  logic       z1_x2_r;
  logic       z2_x2_r;
  prod_vec_t  e_diff;
  prod_vec_t  e_mag;
  prod_vec_t  e_rnd;
  unit_vec_t  e_unit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_diff[i] = qa_r[i] - qb_r[i];
      e_mag[i]  = e_diff[i][PROD_W-1] ? -e_diff[i] : e_diff[i];
      e_rnd[i]  = (e_mag[i] + RND) >> FRAC;
      if (e_rnd[i] > LIM) begin
        e_rnd[i] = LIM;
      end
      e_unit[i] = e_diff[i][PROD_W-1] ? -UNIT_W'(e_rnd[i]) : UNIT_W'(e_rnd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx2_r <= 1'b0;
    end else if (adv) begin
      vx2_r <= vx1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_x2_r    <= e_unit;
      func_x2_r <= func_x1_r;
      u1_x2_r   <= u1_x1_r;
      u2_x2_r   <= u2_x1_r;
      z1_x2_r   <= z1_x1_r;
      z2_x2_r   <= z2_x1_r;
    end
  end

  // Place the axes by mode into the output register
  unit_vec_t xrow_nxt;
  unit_vec_t yrow_nxt;
  unit_vec_t zrow_nxt;
  logic      deg_nxt;
  unit_vec_t w_neg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_neg[i] = -w_x2_r[i];
    end
    xrow_nxt = '0;
    yrow_nxt = '0;
    zrow_nxt = '0;
    deg_nxt  = z1_x2_r || z2_x2_r;
    case (func_x2_r)
      FUNC_Y: begin
        xrow_nxt = w_x2_r;
        yrow_nxt = u1_x2_r;
        zrow_nxt = u2_x2_r;
      end
      FUNC_X: begin
        xrow_nxt = u1_x2_r;
        yrow_nxt = w_neg;
        zrow_nxt = u2_x2_r;
      end
      FUNC_Z: begin
        xrow_nxt = u2_x2_r;
        yrow_nxt = w_x2_r;
        zrow_nxt = u1_x2_r;
      end
      default: begin
        deg_nxt = 1'b1;
      end
    endcase
  end

  unit_vec_t xrow_r;
  unit_vec_t yrow_r;
  unit_vec_t zrow_r;
  logic      deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vx2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xrow_r <= xrow_nxt;
      yrow_r <= yrow_nxt;
      zrow_r <= zrow_nxt;
      deg_r  <= deg_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_xaxis_x    = xrow_r[0];
  assign out_xaxis_y    = xrow_r[1];
  assign out_xaxis_z    = xrow_r[2];
  assign out_yaxis_x    = yrow_r[0];
  assign out_yaxis_y    = yrow_r[1];
  assign out_yaxis_z    = yrow_r[2];
  assign out_zaxis_x    = zrow_r[0];
  assign out_zaxis_y    = zrow_r[1];
  assign out_zaxis_z    = zrow_r[2];
  assign out_degenerate = deg_r;

  // A frame that is not degenerate has a nonzero third row
  a_zrow_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |-> zrow_r != '0)
    else $error("nondegenerate frame with zero third row");

  // The unused mode code always reports degenerate with empty x and y rows
  a_bad_mode: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vx2_r && (func_x2_r != FUNC_Y) && (func_x2_r != FUNC_X) &&
    (func_x2_r != FUNC_Z) |=> out_degenerate && xrow_r == '0 && yrow_r == '0)
    else $error("unused mode did not give an empty degenerate frame");

  // A word taken during a stall sits in the input stage
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !adv |=> v0_r)
    else $error("input word lost during a stall");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for orthonormal_frame_from_two_vectors.
// Needs ofv_pkg and the block's RTL. The frame predictor is built into this file.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ofv_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam longint UNIT_ONE = 64'd1 << FRAC;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic [1:0]         func;
    logic signed [15:0] a [3];
    logic signed [15:0] b [3];
  } vec_pair_t;

  typedef struct {
    logic [15:0] axis [9];
    logic        degenerate;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = '0;
  logic signed [15:0] in_first_x = '0, in_first_y = '0, in_first_z = '0;
  logic signed [15:0] in_second_x = '0, in_second_y = '0, in_second_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_xaxis_x, out_xaxis_y, out_xaxis_z;
  logic signed [15:0] out_yaxis_x, out_yaxis_y, out_yaxis_z;
  logic signed [15:0] out_zaxis_x, out_zaxis_y, out_zaxis_z;
  logic out_degenerate;

  vec_pair_t pending_words [$];
  frame_t    frames_due [$];
  int        mismatches = 0;
  bit        failed = 1'b0;

  orthonormal_frame_from_two_vectors dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Normalize to Q1.14; returns 1 for a zero-length vector
  function automatic bit unit_of(input longint v [3], output longint u [3]);
    longint unsigned mag [3];
    bit neg [3];
    longint unsigned len2, m2, q, t, d;
    logic [127:0] lhs, rhs;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
    end
    while (mag[0] >= 64'h8000_0000 || mag[1] >= 64'h8000_0000 || mag[2] >= 64'h8000_0000)
    begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    len2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    if (len2 == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      m2 = mag[i] * mag[i];
      rhs = {64'd0, m2} << (2 * FRAC + 2);
      q = 0;
      // bitwise search for round(|v_i| * 2^F / |v|)
      for (int bt = FRAC; bt >= 0; bt--) begin
        t = q | (64'd1 << bt);
        if (t <= UNIT_ONE) begin
          d = 2 * t - 1;
          lhs = {64'd0, d * d} * {64'd0, len2};
          if (lhs <= rhs) q = t;
        end
      end
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic void cross3(input longint p [3], input longint q [3], output longint r [3]);
    r[0] = p[1] * q[2] - p[2] * q[1];
    r[1] = p[2] * q[0] - p[0] * q[2];
    r[2] = p[0] * q[1] - p[1] * q[0];
  endfunction

  // Cross of two unit vectors, rounded back to Q1.14 and saturated
  function automatic void cross_q14(input longint p [3], input longint q [3],
                                    output longint r [3]);
    longint e [3];
    longint unsigned m;
    cross3(p, q, e);
    for (int i = 0; i < 3; i++) begin
      m = (e[i] < 0) ? longint'(-e[i]) : longint'(e[i]);
      m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
      if (m > UNIT_ONE) m = UNIT_ONE;
      r[i] = (e[i] < 0) ? -longint'(m) : longint'(m);
    end
  endfunction

  function automatic frame_t frame_of(input vec_pair_t w);
    longint a [3], b [3], t [3];
    longint x [3], y [3], z [3];
    bit deg;
    frame_t f;
    deg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a[i] = w.a[i];
      b[i] = w.b[i];
      x[i] = 0; y[i] = 0; z[i] = 0;
    end
    case (w.func)
      FUNC_Y: begin
        deg |= unit_of(b, y);
        cross3(a, y, t);
        deg |= unit_of(t, z);
        cross_q14(y, z, x);
      end
      FUNC_X: begin
        deg |= unit_of(a, x);
        cross3(x, b, t);
        deg |= unit_of(t, z);
        cross_q14(z, x, y);
      end
      FUNC_Z: begin
        deg |= unit_of(b, z);
        cross3(a, z, t);
        deg |= unit_of(t, x);
        cross_q14(z, x, y);
      end
      default: deg = 1'b1;
    endcase
    for (int i = 0; i < 3; i++) begin
      f.axis[i]     = x[i][15:0];
      f.axis[3 + i] = y[i][15:0];
      f.axis[6 + i] = z[i][15:0];
    end
    f.degenerate = deg;
    return f;
  endfunction

  // Driver: bursts of words with random gaps; predict on each accepted word
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    vec_pair_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        w.func = in_func;
        w.a[0] = in_first_x;  w.a[1] = in_first_y;  w.a[2] = in_first_z;
        w.b[0] = in_second_x; w.b[1] = in_second_y; w.b[2] = in_second_z;
        frames_due.push_back(frame_of(w));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          w = pending_words.pop_front();
          in_valid    <= 1'b1;
          in_func     <= w.func;
          in_first_x  <= w.a[0]; in_first_y  <= w.a[1]; in_first_z  <= w.a[2];
          in_second_x <= w.b[0]; in_second_y <= w.b[1]; in_second_z <= w.b[2];
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Receiver: the stall pattern is drawn anew from four modes over the run, plus one long hold
  int rcv_cycles = 0;
  int rcv_mode = 0;
  always @(posedge clk) begin
    rcv_cycles++;
    if (rcv_cycles % 200 == 0) rcv_mode = $urandom_range(0, 3);
    if (rcv_cycles >= 1000 && rcv_cycles < 1600)
      out_ready <= 1'b0;
    else case (rcv_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((rcv_cycles / 16) % 2 == 0);
    endcase
  end

  // Monitor: compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    frame_t got, want;
    bit bad;
    if (rst_n && out_valid && out_ready) begin
      got.axis[0] = out_xaxis_x; got.axis[1] = out_xaxis_y; got.axis[2] = out_xaxis_z;
      got.axis[3] = out_yaxis_x; got.axis[4] = out_yaxis_y; got.axis[5] = out_yaxis_z;
      got.axis[6] = out_zaxis_x; got.axis[7] = out_zaxis_y; got.axis[8] = out_zaxis_z;
      got.degenerate = out_degenerate;
      if (frames_due.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected output word at %0t", $realtime);
      end else begin
        want = frames_due.pop_front();
        bad = (got.degenerate !== want.degenerate);
        for (int i = 0; i < 9; i++) if (got.axis[i] !== want.axis[i]) bad = 1'b1;
        if (bad) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("frame mismatch at %0t: deg exp %0b got %0b", $realtime,
                     want.degenerate, got.degenerate);
            for (int i = 0; i < 9; i++)
              $display("  row %0d col %0d exp %0d got %0d", i / 3, i % 3,
                       $signed(want.axis[i]), $signed(got.axis[i]));
          end
        end
      end
    end
  end

  // Watchdog: end the run after too long without any handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic vec_pair_t make_word(input logic [1:0] f,
      input int ax, input int ay, input int az, input int bx, input int by, input int bz);
    vec_pair_t w;
    w.func = f;
    w.a[0] = ax; w.a[1] = ay; w.a[2] = az;
    w.b[0] = bx; w.b[1] = by; w.b[2] = bz;
    return w;
  endfunction

  function automatic int rand_coord(input int kind);
    case (kind)
      0: return $signed(16'($urandom));
      1: return $urandom_range(0, 16) - 8;
      2: return $urandom_range(0, 1) ? 32767 : -32768;
      default: return $urandom_range(0, 8192) - 4096;
    endcase
  endfunction

  function automatic vec_pair_t random_word();
    vec_pair_t w;
    int kind, k;
    kind = $urandom_range(0, 9);
    w.func = ($urandom_range(0, 19) == 0) ? FUNC_NONE : 2'($urandom_range(0, 2));
    for (int i = 0; i < 3; i++) begin
      w.a[i] = rand_coord(kind % 4);
      w.b[i] = rand_coord($urandom_range(0, 3));
    end
    // zero vector or parallel pair now and then
    if (kind == 8) begin
      for (int i = 0; i < 3; i++)
        if ($urandom_range(0, 1)) w.a[i] = 0; else w.b[i] = 0;
      if ($urandom_range(0, 1)) for (int i = 0; i < 3; i++) w.a[i] = 0;
      else for (int i = 0; i < 3; i++) w.b[i] = 0;
    end else if (kind == 9) begin
      k = $urandom_range(0, 1) ? 2 : -1;
      for (int i = 0; i < 3; i++) begin
        w.a[i] = rand_coord(1) * 100;
        w.b[i] = w.a[i] * k;
      end
    end
    return w;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every mode, axes, zero, parallel, extremes, unused code
    for (int f = 0; f < 4; f++) begin
      pending_words.push_back(make_word(2'(f), 4096, 0, 0, 0, 4096, 0));
      pending_words.push_back(make_word(2'(f), 1000, -2000, 3000, -500, 700, 900));
      pending_words.push_back(make_word(2'(f), 0, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(2'(f), 300, 600, -900, -600, -1200, 1800));
      pending_words.push_back(make_word(2'(f), -32768, -32768, -32768,
                                        32767, 32767, -32768));
    end
    pending_words.push_back(make_word(FUNC_Y, 32767, 32767, 32767, 1, 0, 0));
    pending_words.push_back(make_word(FUNC_X, 1, 0, 0, 0, 0, 1));
    pending_words.push_back(make_word(FUNC_Z, 5, -7, 3, 0, 0, 0));
    wait (pending_words.size() == 0 && !in_valid);

    // Hold the sender until every prediction has been matched
    wait (frames_due.size() == 0);
    repeat (20) @(posedge clk);

    for (int n = 0; n < 1130; n++) pending_words.push_back(random_word());
    wait (pending_words.size() == 0 && !in_valid);
    wait (frames_due.size() == 0);
    repeat (150) @(posedge clk);

    if (!failed && frames_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ofv_pkg.sv
design/ofv_norm.sv
design/orthonormal_frame_from_two_vectors.sv
dv/tb.sv
